FILE: hw/rtl/ppv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pinhole projection package
// Shared widths, codes and types for the projection and visibility pipeline.
// ----------------------------------------------------------------------------
package ppv_pkg;

    localparam int WORD_W     = 32;
    localparam int POSE_WORDS = 12;
    localparam int IDX_W      = 4;
    localparam int CFG_IDX_W  = 3;

    // Camera coordinate after the floor shift: 50 bits plus translation.
    localparam int CAM_W = 51;
    // Numerator magnitude: unsigned 32 by signed 32 stays below 2^63.
    localparam int MAG_W = 63;
    // One quotient bit per divider stage.
    localparam int DIV_STAGES = MAG_W;
    // Projected coordinate with center added, before saturation.
    localparam int PIX_W = 65;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_PROJECT = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_LEFT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_RIGHT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_TOP    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_BOTTOM = 3'd7;

    typedef logic [WORD_W-1:0] t_word;
    typedef t_word [POSE_WORDS-1:0] t_pose;

    typedef struct packed {
        logic valid;
        logic depth_ok;
    } t_side;

endpackage

`default_nettype wire

FILE: hw/rtl/ppv_transform.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pose transform
// Three stages: nine products, row sums, then floor to Q16.16 with the
// translation added, saturation of x and y, and the depth range test.
// ----------------------------------------------------------------------------
module ppv_transform #(
    parameter int NEAR_DIST = 655,
    parameter int FAR_DIST  = 32768000
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_en,
    input  wire                        i_valid,
    input  wire ppv_pkg::t_pose        i_pose,
    input  wire [ppv_pkg::WORD_W-1:0]  i_point_x,
    input  wire [ppv_pkg::WORD_W-1:0]  i_point_y,
    input  wire [ppv_pkg::WORD_W-1:0]  i_point_z,
    output ppv_pkg::t_side             o_side,
    output logic [ppv_pkg::WORD_W-1:0] o_xc,
    output logic [ppv_pkg::WORD_W-1:0] o_yc,
    output logic [ppv_pkg::WORD_W-1:0] o_zc
);

    localparam int W  = ppv_pkg::WORD_W;
    localparam int CW = ppv_pkg::CAM_W;
    localparam int PW = 2 * W;
    localparam int SW = PW + 2;

    logic                r1_valid;
    logic signed [PW-1:0] r1_prod [0:8];
    logic [W-1:0]        r1_trans [0:2];
    logic                r2_valid;
    logic signed [SW-1:0] r2_sum [0:2];
    logic [W-1:0]        r2_trans [0:2];
    logic signed [CW-1:0] n_cam [0:2];
    logic                n_depth_ok;
    logic [W-1:0]        pt [0:2];
    ppv_pkg::t_side      r3_side;
    logic [W-1:0]        r3_xc;
    logic [W-1:0]        r3_yc;
    logic [W-1:0]        r3_zc;

    function automatic logic [W-1:0] sat_cam(input logic signed [CW-1:0] c);
        if (c[CW-1:W-1] == {(CW-W+1){c[W-1]}}) begin
            sat_cam = c[W-1:0];
        end else begin
            sat_cam = c[CW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end
    endfunction

    assign pt[0] = i_point_x;
    assign pt[1] = i_point_y;
    assign pt[2] = i_point_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r1_prod[r*3+c] <= $signed(i_pose[r*4+c]) * $signed(pt[c]);
                end
                r1_trans[r] <= i_pose[r*4+3];
                r2_sum[r]   <= $signed({{2{r1_prod[r*3][PW-1]}}, r1_prod[r*3]})
                             + $signed({{2{r1_prod[r*3+1][PW-1]}}, r1_prod[r*3+1]})
                             + $signed({{2{r1_prod[r*3+2][PW-1]}}, r1_prod[r*3+2]});
                r2_trans[r] <= r1_trans[r];
            end
        end
    end

    // The arithmetic right shift by 16 is the floor to Q16.16.
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_cam[r] = $signed({r2_sum[r][SW-1], r2_sum[r][SW-1:16]})
                     + $signed({{(CW-W){r2_trans[r][W-1]}}, r2_trans[r]});
        end
        n_depth_ok = (n_cam[2] >= $signed(CW'(NEAR_DIST)))
                  && (n_cam[2] <= $signed(CW'(FAR_DIST)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_side <= '0;
        end else if (i_en) begin
            r3_side.valid    <= r2_valid;
            r3_side.depth_ok <= n_depth_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_xc <= sat_cam(n_cam[0]);
            r3_yc <= sat_cam(n_cam[1]);
            r3_zc <= n_cam[2][W-1:0];
        end
    end

    assign o_side = r3_side;
    assign o_xc   = r3_xc;
    assign o_yc   = r3_yc;
    assign o_zc   = r3_zc;

endmodule

`default_nettype wire

FILE: hw/rtl/ppv_scale.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Focal scaling
// Two stages: focal length times camera coordinate as an exact Q32.32
// product, then split into sign and magnitude for the divider.
// ----------------------------------------------------------------------------
module ppv_scale (
    input  wire                        i_clk,
    input  wire                        i_en,
    input  wire [ppv_pkg::WORD_W-1:0]  i_focal,
    input  wire [ppv_pkg::WORD_W-1:0]  i_coord,
    output logic [ppv_pkg::MAG_W-1:0]  o_mag,
    output logic                       o_neg
);

    localparam int W  = ppv_pkg::WORD_W;
    localparam int NW = 2 * W + 1;

    logic signed [NW-1:0] r_prod;
    logic [NW-1:0]        n_abs;
    logic [ppv_pkg::MAG_W-1:0] r_mag;
    logic                 r_neg;

    assign n_abs = r_prod[NW-1] ? NW'(-r_prod) : NW'(r_prod);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= $signed({1'b0, i_focal}) * $signed(i_coord);
            r_neg  <= r_prod[NW-1];
            r_mag  <= n_abs[ppv_pkg::MAG_W-1:0];
        end
    end

    assign o_mag = r_mag;
    assign o_neg = r_neg;

endmodule

`default_nettype wire

FILE: hw/rtl/ppv_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined divider
// Restoring division, one quotient bit per stage, on magnitudes; the sign
// is applied at the end so the quotient truncates toward zero.
// ----------------------------------------------------------------------------
module ppv_divider (
    input  wire                        i_clk,
    input  wire                        i_en,
    input  wire [ppv_pkg::MAG_W-1:0]   i_num,
    input  wire                        i_neg,
    input  wire [ppv_pkg::WORD_W-1:0]  i_den,
    output logic [ppv_pkg::MAG_W:0]    o_quo
);

    localparam int N  = ppv_pkg::DIV_STAGES;
    localparam int MW = ppv_pkg::MAG_W;
    localparam int W  = ppv_pkg::WORD_W;

    logic [W-1:0]  r_rem [0:N-1];
    logic [MW-1:0] r_num [0:N-1];
    logic [MW-1:0] r_quo [0:N-1];
    logic [W-1:0]  r_den [0:N-1];
    logic          r_neg [0:N-1];

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic [W-1:0]  p_rem;
        logic [MW-1:0] p_num;
        logic [MW-1:0] p_quo;
        logic [W-1:0]  p_den;
        logic          p_neg;
        logic [W:0]    trial;
        logic          ge;

        if (k == 0) begin : g_first
            assign p_rem = '0;
            assign p_num = i_num;
            assign p_quo = '0;
            assign p_den = i_den;
            assign p_neg = i_neg;
        end else begin : g_next
            assign p_rem = r_rem[k-1];
            assign p_num = r_num[k-1];
            assign p_quo = r_quo[k-1];
            assign p_den = r_den[k-1];
            assign p_neg = r_neg[k-1];
        end

        assign trial = {p_rem, p_num[MW-1]};
        assign ge    = trial >= {1'b0, p_den};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? W'(trial - {1'b0, p_den}) : trial[W-1:0];
                r_num[k] <= {p_num[MW-2:0], 1'b0};
                r_quo[k] <= {p_quo[MW-2:0], ge};
                r_den[k] <= p_den;
                r_neg[k] <= p_neg;
            end
        end
    end

    assign o_quo = r_neg[N-1] ? (MW+1)'(-{1'b0, r_quo[N-1]}) : {1'b0, r_quo[N-1]};

endmodule

`default_nettype wire

FILE: hw/rtl/pinhole_projection_visibility_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pinhole projection and visibility unit
// A load beat (tuser 0) with an index below 12 writes one pose word; a
// project beat (tuser 1) transforms a world point, tests depth and image
// bounds, and returns one result beat. The unit accepts one beat per clock
// unless the master side stalls; a result passes through three transform
// stages, two scaling stages, the 63-stage bit-per-stage divider and two
// output stages. All stages move together on one enable, so a stall on the
// master side holds the whole pipeline and s_axis_tready follows it.
// ----------------------------------------------------------------------------
module pinhole_projection_visibility_unit #(
    parameter int NEAR_DIST = 655,
    parameter int FAR_DIST  = 32768000
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // pose_index[3:0], pose_word[35:4], point_x[67:36], point_y[99:68],
    // point_z[131:100], zero fill[135:132]
    input  wire  [135:0] s_axis_tdata,
    // cmd[0]
    input  wire  [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // pixel_u[31:0], pixel_v[63:32]
    output logic [63:0]  m_axis_tdata,
    // visible[0]
    output logic [0:0]   m_axis_tuser,
    input  wire          i_cfg_we,
    input  wire  [ppv_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  wire  [ppv_pkg::WORD_W-1:0]    i_cfg_data
);

    localparam int W   = ppv_pkg::WORD_W;
    localparam int PXW = ppv_pkg::PIX_W;
    localparam int LAT = 2 + ppv_pkg::DIV_STAGES;

    logic [W-1:0] r_focal_x, r_focal_y, r_center_x, r_center_y;
    logic [W-1:0] r_left, r_right, r_top, r_bottom;
    ppv_pkg::t_pose r_pose;

    logic en, accept, proj_valid;
    logic [ppv_pkg::IDX_W-1:0] in_idx;

    ppv_pkg::t_side tf_side;
    logic [W-1:0]   tf_xc, tf_yc, tf_zc;
    logic [W-1:0]   r_zc_d1, r_zc_d2;
    logic [ppv_pkg::MAG_W-1:0] mag_u, mag_v;
    logic           neg_u, neg_v;
    logic [ppv_pkg::MAG_W:0] quo_u, quo_v;

    ppv_pkg::t_side r_side [0:LAT-1];
    ppv_pkg::t_side r_f1_side;
    logic signed [PXW-1:0] r_f1_u, r_f1_v;
    logic n_vis;

    logic         r_out_valid, r_out_vis;
    logic [W-1:0] r_out_u, r_out_v;

    function automatic logic [W-1:0] sat_pix(input logic signed [PXW-1:0] p);
        if (p[PXW-1:W-1] == {(PXW-W+1){p[W-1]}}) begin
            sat_pix = p[W-1:0];
        end else begin
            sat_pix = p[PXW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end
    endfunction

    assign en            = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en;
    assign accept        = s_axis_tvalid && en;
    assign proj_valid    = accept && (s_axis_tuser[0] == ppv_pkg::CMD_PROJECT);
    assign in_idx        = s_axis_tdata[3:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal_x  <= '0;
            r_focal_y  <= '0;
            r_center_x <= '0;
            r_center_y <= '0;
            r_left     <= '0;
            r_right    <= '0;
            r_top      <= '0;
            r_bottom   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                ppv_pkg::CFG_FOCAL_X:      r_focal_x  <= i_cfg_data;
                ppv_pkg::CFG_FOCAL_Y:      r_focal_y  <= i_cfg_data;
                ppv_pkg::CFG_CENTER_X:     r_center_x <= i_cfg_data;
                ppv_pkg::CFG_CENTER_Y:     r_center_y <= i_cfg_data;
                ppv_pkg::CFG_BOUND_LEFT:   r_left     <= i_cfg_data;
                ppv_pkg::CFG_BOUND_RIGHT:  r_right    <= i_cfg_data;
                ppv_pkg::CFG_BOUND_TOP:    r_top      <= i_cfg_data;
                ppv_pkg::CFG_BOUND_BOTTOM: r_bottom   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // A load beat lands before any later project beat reaches the products.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pose <= '0;
        end else if (accept && (s_axis_tuser[0] == ppv_pkg::CMD_LOAD)
                     && (in_idx < ppv_pkg::IDX_W'(ppv_pkg::POSE_WORDS))) begin
            r_pose[in_idx] <= s_axis_tdata[35:4];
        end
    end

    ppv_transform #(
        .NEAR_DIST (NEAR_DIST),
        .FAR_DIST  (FAR_DIST)
    ) u_transform (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (proj_valid),
        .i_pose    (r_pose),
        .i_point_x (s_axis_tdata[67:36]),
        .i_point_y (s_axis_tdata[99:68]),
        .i_point_z (s_axis_tdata[131:100]),
        .o_side    (tf_side),
        .o_xc      (tf_xc),
        .o_yc      (tf_yc),
        .o_zc      (tf_zc)
    );

    ppv_scale u_scale_u (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_focal (r_focal_x),
        .i_coord (tf_xc),
        .o_mag   (mag_u),
        .o_neg   (neg_u)
    );

    ppv_scale u_scale_v (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_focal (r_focal_y),
        .i_coord (tf_yc),
        .o_mag   (mag_v),
        .o_neg   (neg_v)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_zc_d1 <= tf_zc;
            r_zc_d2 <= r_zc_d1;
        end
    end

    ppv_divider u_div_u (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (mag_u),
        .i_neg (neg_u),
        .i_den (r_zc_d2),
        .o_quo (quo_u)
    );

    ppv_divider u_div_v (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (mag_v),
        .i_neg (neg_v),
        .i_den (r_zc_d2),
        .o_quo (quo_v)
    );

    // Sideband follows the scaling and divider stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_side[k] <= '0;
            end
            r_f1_side <= '0;
        end else if (en) begin
            r_side[0] <= tf_side;
            for (int k = 1; k < LAT; k++) begin
                r_side[k] <= r_side[k-1];
            end
            r_f1_side <= r_side[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f1_u <= $signed({quo_u[ppv_pkg::MAG_W], quo_u})
                    + $signed({{(PXW-W){r_center_x[W-1]}}, r_center_x});
            r_f1_v <= $signed({quo_v[ppv_pkg::MAG_W], quo_v})
                    + $signed({{(PXW-W){r_center_y[W-1]}}, r_center_y});
        end
    end

    always_comb begin
        n_vis = r_f1_side.depth_ok
             && (r_f1_u >= $signed({{(PXW-W){r_left[W-1]}}, r_left}))
             && (r_f1_u <= $signed({{(PXW-W){r_right[W-1]}}, r_right}))
             && (r_f1_v >= $signed({{(PXW-W){r_top[W-1]}}, r_top}))
             && (r_f1_v <= $signed({{(PXW-W){r_bottom[W-1]}}, r_bottom}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_f1_side.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_vis <= n_vis;
            r_out_u   <= n_vis ? sat_pix(r_f1_u) : '0;
            r_out_v   <= n_vis ? sat_pix(r_f1_v) : '0;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tuser[0] = r_out_vis;
    assign m_axis_tdata    = {r_out_v, r_out_u};

    a_hidden_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_vis |-> (r_out_u == '0) && (r_out_v == '0))
        else $error("hidden point carries a nonzero pixel");

    a_u_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_vis |->
            ($signed(r_out_u) >= $signed(r_left)) && ($signed(r_out_u) <= $signed(r_right)))
        else $error("visible column outside the bounds");

    a_v_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_vis |->
            ($signed(r_out_v) >= $signed(r_top)) && ($signed(r_out_v) <= $signed(r_bottom)))
        else $error("visible row outside the bounds");

    a_pose_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (s_axis_tuser[0] == ppv_pkg::CMD_LOAD)
            && (in_idx < ppv_pkg::IDX_W'(ppv_pkg::POSE_WORDS))
        |=> r_pose[$past(in_idx)] == $past(s_axis_tdata[35:4]))
        else $error("pose word not stored");

endmodule

`default_nettype wire
